// ===== src/md4sh_pkg.sv =====
// md4sh_pkg: shared types and constants of the md4 stream hasher
// no dependencies; imported by the controller, datapath, checker and top level
`timescale 1ns / 1ps

package md4sh_pkg;

  localparam int unsigned WORDS  = 16;
  localparam int unsigned ROUNDS = 48;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LAST_OFFSET = 6'h3f;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] LAST_ROUND  = 6'(ROUNDS - 1);

  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [1:0] LAST_INDEX  = 2'd3;

  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;

  // message word order over the three rounds
  localparam logic [3:0] MSG_ORDER [ROUNDS] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FEED,
    S_OUT
  } md4sh_state_t;

  // which kind of block the compression sees
  typedef enum logic [1:0] {
    MODE_DATA,
    MODE_PAD1,
    MODE_PAD2
  } md4sh_mode_t;

  typedef struct packed {
    logic        byte_wr;
    logic        load;
    logic        step;
    logic        feed;
    logic        reinit;
    md4sh_mode_t mode;
    logic [1:0]  out_idx;
  } md4sh_cmd_t;

  typedef struct packed {
    logic [5:0] offset;
    logic       last_round;
    logic       pad_two;
  } md4sh_status_t;

  function automatic logic [4:0] rot_amount(input logic [1:0] grp, input logic [1:0] step);
    logic [4:0] s;
    begin
      case ({grp, step})
        4'h0: s = 5'd3;
        4'h1: s = 5'd7;
        4'h2: s = 5'd11;
        4'h3: s = 5'd19;
        4'h4: s = 5'd3;
        4'h5: s = 5'd5;
        4'h6: s = 5'd9;
        4'h7: s = 5'd13;
        4'h8: s = 5'd3;
        4'h9: s = 5'd9;
        4'ha: s = 5'd11;
        4'hb: s = 5'd15;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

endpackage

// ===== src/md4sh_if.sv =====
// md4sh_msg_if, md4sh_digest_if: valid/ready channels of the md4 stream hasher
// no dependencies
`timescale 1ns / 1ps

interface md4sh_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface md4sh_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/md4_stream_hasher.sv =====
// md4_stream_hasher: top level of the md4 stream hasher
// depends on md4sh_pkg, md4sh_if, md4sh_ctrl and md4sh_dp
`timescale 1ns / 1ps

// usage
// - msg channel: one request per message byte; byte_valid marks a real byte,
//   end_of_message closes the message after that request's byte (if any)
// - digest channel: four requests per message, word 0 first, last_word on word 3;
//   digest bytes are each word's bytes, low byte first
// - a request without a compression is taken at once and ready stays high,
//   so a byte stream runs at one byte per cycle between compressions
// - every 64th byte starts a compression (a load, 48 rounds, a feed), during
//   which msg.ready stays low; a single round unit does the rounds
// - end of message: one or two padded compressions (after a data compression if
//   the same request also filled a block), then the four digest words
// - the block works on one request at a time; msg.ready is low while the
//   digest is shown
// - a stalled digest receiver simply holds the current word; nothing is lost
// - reset (synchronous, active high) loads the standard initial words and
//   clears the byte count; the same happens after the last digest word leaves
module md4_stream_hasher (
  input  logic           clk,
  input  logic           rst,
  md4sh_msg_if.sink      msg,
  md4sh_digest_if.source digest
);
  import md4sh_pkg::*;

  md4sh_cmd_t    cmd;
  md4sh_status_t status;
  logic [31:0]   digest_word;

  // sequencer: handshakes, pass selection, digest word index
  md4sh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (msg.valid),
    .byte_valid     (msg.byte_valid),
    .end_of_message (msg.end_of_message),
    .in_ready       (msg.ready),
    .out_valid      (digest.valid),
    .out_ready      (digest.ready),
    .status         (status),
    .cmd            (cmd)
  );

  // storage and the round unit
  md4sh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (msg.data_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word)
  );

  // digest payload straight from registers
  assign digest.digest_word = digest_word;
  assign digest.word_index  = cmd.out_idx;
  assign digest.last_word   = (cmd.out_idx == LAST_INDEX);

endmodule

// ===== src/md4sh_ctrl.sv =====
// md4sh_ctrl: sequencing state machine of the md4 stream hasher
// depends on md4sh_pkg
`timescale 1ns / 1ps

module md4sh_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   byte_valid,
  input  logic                   end_of_message,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  md4sh_pkg::md4sh_status_t status,
  output md4sh_pkg::md4sh_cmd_t    cmd
);
  import md4sh_pkg::*;

  md4sh_state_t state, state_next;
  md4sh_mode_t  mode, mode_next;
  logic         pend, pend_next;
  logic [1:0]   out_idx, out_idx_next;
  logic         in_acc, out_acc;

  assign in_acc  = in_valid && (state == S_IDLE);
  assign out_acc = out_ready && (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mode    <= MODE_DATA;
      pend    <= 1'b0;
      out_idx <= '0;
    end else begin
      state   <= state_next;
      mode    <= mode_next;
      pend    <= pend_next;
      out_idx <= out_idx_next;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    mode_next    = mode;
    pend_next    = pend;
    out_idx_next = out_idx;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (byte_valid && status.offset == LAST_OFFSET) begin
            mode_next  = MODE_DATA;
            pend_next  = end_of_message;
            state_next = S_LOAD;
          end else if (end_of_message) begin
            mode_next  = MODE_PAD1;
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: state_next = S_ROUND;
      S_ROUND: begin
        if (status.last_round) state_next = S_FEED;
      end
      S_FEED: begin
        case (mode)
          MODE_DATA: begin
            if (pend) begin
              mode_next  = MODE_PAD1;
              pend_next  = 1'b0;
              state_next = S_LOAD;
            end else begin
              state_next = S_IDLE;
            end
          end
          MODE_PAD1: begin
            if (status.pad_two) begin
              mode_next  = MODE_PAD2;
              state_next = S_LOAD;
            end else begin
              state_next = S_OUT;
            end
          end
          default: state_next = S_OUT;
        endcase
      end
      S_OUT: begin
        if (out_acc) begin
          out_idx_next = out_idx + 2'd1;
          if (out_idx == LAST_INDEX) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = (state == S_IDLE);
    out_valid   = (state == S_OUT);
    cmd.byte_wr = in_acc && byte_valid;
    cmd.load    = (state == S_LOAD);
    cmd.step    = (state == S_ROUND);
    cmd.feed    = (state == S_FEED);
    cmd.reinit  = out_acc && (out_idx == LAST_INDEX);
    cmd.mode    = mode;
    cmd.out_idx = out_idx;
  end

endmodule

// ===== src/md4sh_dp.sv =====
// md4sh_dp: message block, byte count, round unit and chaining words
// depends on md4sh_pkg
`timescale 1ns / 1ps

module md4sh_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               data_byte,
  input  md4sh_pkg::md4sh_cmd_t    cmd,
  output md4sh_pkg::md4sh_status_t status,
  output logic [31:0]              digest_word
);
  import md4sh_pkg::*;

  logic [31:0] blk [WORDS];
  logic [31:0] h [4];
  logic [31:0] a, b, c, d;
  logic [63:0] length;
  logic [5:0]  round;

  logic [5:0]  offset;
  logic [63:0] bit_len;
  logic [3:0]  x_idx;
  logic [31:0] x_raw, x_word;
  logic [1:0]  grp, stp;
  logic [31:0] f, k, sum;
  logic [63:0] rot_wide;
  logic [31:0] a_new;

  assign offset  = length[5:0];
  assign bit_len = {length[60:0], 3'b000};

  assign status.offset     = offset;
  assign status.last_round = (round == LAST_ROUND);
  assign status.pad_two    = (offset >= LEN_OFFSET);

  assign digest_word = h[cmd.out_idx];

  // word fetch with padding applied on the fly
  assign x_idx = MSG_ORDER[round];
  assign x_raw = blk[x_idx];

  always_comb begin
    logic [5:0] p;
    x_word = x_raw;
    for (int l = 0; l < 4; l++) begin
      p = {x_idx, 2'(l)};
      if (cmd.mode == MODE_PAD2) begin
        x_word[8*l +: 8] = '0;
      end else if (cmd.mode == MODE_PAD1) begin
        if (p == offset) x_word[8*l +: 8] = PAD_BYTE;
        else if (p > offset) x_word[8*l +: 8] = '0;
      end
    end
    if (cmd.mode == MODE_PAD2 || (cmd.mode == MODE_PAD1 && !status.pad_two)) begin
      if (x_idx == LEN_LO_WORD) x_word = bit_len[31:0];
      else if (x_idx == LEN_HI_WORD) x_word = bit_len[63:32];
    end
  end

  // one round per cycle
  assign grp = round[5:4];
  assign stp = round[1:0];

  always_comb begin
    case (grp)
      GRP_F: begin
        f = (b & c) | (~b & d);
        k = '0;
      end
      GRP_G: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND2;
      end
      GRP_H: begin
        f = b ^ c ^ d;
        k = K_ROUND3;
      end
      default: begin
        f = '0;
        k = '0;
      end
    endcase
  end

  assign sum      = a + f + x_word + k;
  assign rot_wide = {sum, sum} << rot_amount(grp, stp);
  assign a_new    = rot_wide[63:32];

  always_ff @(posedge clk) begin
    if (cmd.byte_wr) blk[offset[5:2]][{offset[1:0], 3'b000} +: 8] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
    end else if (cmd.step) begin
      // rotate the working words so the updated one always sits in b
      a <= d;
      b <= a_new;
      c <= b;
      d <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) round <= '0;
    else if (cmd.step) round <= round + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      h[0]   <= IV_A;
      h[1]   <= IV_B;
      h[2]   <= IV_C;
      h[3]   <= IV_D;
      length <= '0;
    end else begin
      if (cmd.feed) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
      end
      if (cmd.byte_wr) length <= length + 64'd1;
    end
  end

endmodule

// ===== src/md4sh_checker.sv =====
// md4sh_checker: port-level assertions of the md4 stream hasher, bound to the top
// depends on md4sh_pkg and md4_stream_hasher
`timescale 1ns / 1ps

module md4sh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        byte_valid,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last_word
);
  import md4sh_pkg::*;

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  // one request at a time: no input taken while the digest is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while digest pending");

  // digest words come in order and the burst ends after the last one
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == $past(word_index) + 2'd1)
    else $error("digest word out of order");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> !out_valid && in_ready)
    else $error("digest burst did not end");

  // an empty request causes no work
  a_empty_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !byte_valid && !end_of_message |=> in_ready)
    else $error("empty request stalled the input");

endmodule

bind md4_stream_hasher md4sh_checker u_md4sh_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (msg.valid),
  .in_ready       (msg.ready),
  .byte_valid     (msg.byte_valid),
  .end_of_message (msg.end_of_message),
  .out_valid      (digest.valid),
  .out_ready      (digest.ready),
  .digest_word    (digest.digest_word),
  .word_index     (digest.word_index),
  .last_word      (digest.last_word)
);
